[rtl/core/ccd_pivot_angle_defines.svh]
// Assertion macros shared by the pivot angle design.
`ifndef CCD_PIVOT_ANGLE_DEFINES_SVH
`define CCD_PIVOT_ANGLE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define CPA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that implies another one in the following cycle.
`define CPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/cpa_pkg.sv]
package cpa_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned AngleW = 20;
  localparam int unsigned AngQ = 30;
  localparam int unsigned CordicSteps = 31;
  localparam int unsigned NormW = 16;
  localparam logic signed [33:0] HalfPiQ30 = 34'sd1686629713;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0: r = 34'sd843314857;
      5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043837;
      5'd3: r = 34'sd133525159;
      5'd4: r = 34'sd67021687;
      5'd5: r = 34'sd33543516;
      5'd6: r = 34'sd16775851;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194283;
      5'd9: r = 34'sd2097149;
      default: r = 34'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage

[rtl/core/ccd_pivot_angle.sv]
// Pivot angle kernel for one cyclic coordinate descent step. Each item carries
// pivot, next, chain end and target points; the result is the rotation angle
// psi in Q.FRAC_BITS radians and a flag that is low when no usable angle
// exists. The pipeline takes one item per cycle while the output side does not
// stall; an item passes six front stages, the 32-stage square root of |b|, one
// multiply stage and the 31-stage CORDIC vectoring chain, plus the output
// register. A stall on the output side freezes the whole pipeline.
module ccd_pivot_angle
  import cpa_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pivot_x, pivot_y, pivot_z, next_x, next_y, next_z, end_x, end_y, end_z,
  // target_x, target_y, target_z
  input  logic [383:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // rotation_angle, angle_valid, zero fill
  output logic [23:0]  m_tdata
);

  `include "ccd_pivot_angle_defines.svh"

  localparam int unsigned SqD = 32;
  localparam int unsigned Depth = 7 + SqD + CordicSteps;
  localparam int unsigned RoundS = AngQ - FRAC_BITS;
  localparam logic signed [33:0] Hp =
    (HalfPiQ30 + (34'sd1 <<< (RoundS - 1))) >>> RoundS;

  logic adv;
  logic [Depth-1:0] vld;
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Stage 1: differences.
  logic signed [CoordW:0] b1 [3], d1 [3], h1 [3];
  // Stage 2: normalised vectors.
  logic signed [NormW-1:0] b2 [3], d2 [3], h2 [3], bn [3], dn [3], hn [3];
  logic ok2, okb, okd, okh;
  // Stage 3: cross products.
  logic signed [31:0] p3 [3], q3 [3];
  logic signed [NormW-1:0] d3 [3];
  logic [31:0] bb3;
  logic ok3;
  // Stage 4: products for the dot sums.
  logic signed [63:0] pn4 [3], tn4 [3];
  logic [31:0] bb4;
  logic ok4;
  // Stage 5: dot sums.
  logic signed [65:0] n5, t5;
  logic [31:0] bb5;
  logic ok5;
  // Stage 6: classify and normalise.
  logic signed [30:0] n6, t6;
  logic [31:0] bb6;
  logic [1:0] cls6;
  logic tpos6;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], s_tvalid};
    end
  end

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_diff
      always_ff @(posedge clk) begin
        if (adv) begin
          b1[g] <= (CoordW+1)'($signed(s_tdata[(3+g)*32 +: 32]))
                 - (CoordW+1)'($signed(s_tdata[g*32 +: 32]));
          h1[g] <= (CoordW+1)'($signed(s_tdata[(6+g)*32 +: 32]))
                 - (CoordW+1)'($signed(s_tdata[g*32 +: 32]));
          d1[g] <= (CoordW+1)'($signed(s_tdata[(9+g)*32 +: 32]))
                 - (CoordW+1)'($signed(s_tdata[g*32 +: 32]));
        end
      end
    end
  endgenerate

  cpa_norm u_nb (.a0(b1[0]), .a1(b1[1]), .a2(b1[2]),
                 .v0(bn[0]), .v1(bn[1]), .v2(bn[2]), .nonzero(okb));
  cpa_norm u_nd (.a0(d1[0]), .a1(d1[1]), .a2(d1[2]),
                 .v0(dn[0]), .v1(dn[1]), .v2(dn[2]), .nonzero(okd));
  cpa_norm u_nh (.a0(h1[0]), .a1(h1[1]), .a2(h1[2]),
                 .v0(hn[0]), .v1(hn[1]), .v2(hn[2]), .nonzero(okh));

  logic signed [65:0] nmag, tmag, mx;
  logic [6:0] ld;
  logic signed [97:0] ns, ts;

  always_comb begin
    nmag = n5;
    tmag = t5[65] ? -t5 : t5;
    mx = (tmag > nmag) ? tmag : nmag;
    ld = '0;
    for (int k = 0; k < 66; k++) begin
      if (mx[k]) begin
        ld = 7'(k);
      end
    end
    ns = $signed({n5, 32'd0}) >>> (7'd32 + ld - 7'd28);
    ts = $signed({t5, 32'd0}) >>> (7'd32 + ld - 7'd28);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2 <= bn;
      d2 <= dn;
      h2 <= hn;
      ok2 <= okb && okd && okh;
      q3[0] <= 32'(b2[1] * h2[2]) - 32'(b2[2] * h2[1]);
      q3[1] <= 32'(b2[2] * h2[0]) - 32'(b2[0] * h2[2]);
      q3[2] <= 32'(b2[0] * h2[1]) - 32'(b2[1] * h2[0]);
      p3[0] <= 32'(b2[1] * d2[2]) - 32'(b2[2] * d2[1]);
      p3[1] <= 32'(b2[2] * d2[0]) - 32'(b2[0] * d2[2]);
      p3[2] <= 32'(b2[0] * d2[1]) - 32'(b2[1] * d2[0]);
      bb3 <= 32'(b2[0] * b2[0]) + 32'(b2[1] * b2[1]) + 32'(b2[2] * b2[2]);
      d3 <= d2;
      ok3 <= ok2;
      for (int k = 0; k < 3; k++) begin
        pn4[k] <= p3[k] * q3[k];
        tn4[k] <= 64'(d3[k] * q3[k]);
      end
      bb4 <= bb3;
      ok4 <= ok3;
      n5 <= 66'(pn4[0]) + 66'(pn4[1]) + 66'(pn4[2]);
      t5 <= 66'(tn4[0]) + 66'(tn4[1]) + 66'(tn4[2]);
      bb5 <= bb4;
      ok5 <= ok4;
      bb6 <= bb5;
      n6 <= 31'(ns);
      t6 <= 31'(ts);
      tpos6 <= !t5[65];
      if (!ok5 || n5[65] || (n5 == '0 && t5 == '0)) begin
        cls6 <= 2'd0;
      end else if (n5 == '0) begin
        cls6 <= 2'd1;
      end else begin
        cls6 <= 2'd2;
      end
    end
  end

  // Square root of bb * 2^32, one result bit per stage.
  logic [63:0] sx [SqD+1];
  logic [32:0] sr [SqD+1];
  logic signed [30:0] sn [SqD+1], st [SqD+1];
  logic [1:0] sc [SqD+1];
  logic sp [SqD+1];
  assign sx[0] = {bb6, 32'd0};
  assign sr[0] = '0;
  assign sn[0] = n6;
  assign st[0] = t6;
  assign sc[0] = cls6;
  assign sp[0] = tpos6;

  generate
    for (g = 0; g < SqD; g++) begin : g_sqrt
      logic [65:0] trial;
      assign trial = 66'({sr[g], 2'b01}) << (2 * (SqD - 1 - g));
      always_ff @(posedge clk) begin
        if (adv) begin
          if (66'(sx[g]) >= trial) begin
            sx[g+1] <= 64'(66'(sx[g]) - trial);
            sr[g+1] <= {sr[g][31:0], 1'b1};
          end else begin
            sx[g+1] <= sx[g];
            sr[g+1] <= {sr[g][31:0], 1'b0};
          end
          sn[g+1] <= sn[g];
          st[g+1] <= st[g];
          sc[g+1] <= sc[g];
          sp[g+1] <= sp[g];
        end
      end
    end
  endgenerate

  // CORDIC vectoring.
  logic signed [65:0] cx [CordicSteps+1], cy [CordicSteps+1];
  logic signed [33:0] cz [CordicSteps+1];
  logic [1:0] cc [CordicSteps+1];
  logic cp [CordicSteps+1];
  logic signed [63:0] ymul;
  logic signed [30:0] ynum;
  logic [1:0] ycls;
  logic ypos;

  always_ff @(posedge clk) begin
    if (adv) begin
      ymul <= $signed({1'b0, sr[SqD][31:0]}) * st[SqD];
      ynum <= sn[SqD];
      ycls <= sc[SqD];
      ypos <= sp[SqD];
    end
  end
  assign cx[0] = 66'(ynum) <<< 16;
  assign cy[0] = 66'(ymul);
  assign cz[0] = '0;
  assign cc[0] = ycls;
  assign cp[0] = ypos;

  generate
    for (g = 0; g < CordicSteps; g++) begin : g_cordic
      always_ff @(posedge clk) begin
        if (adv) begin
          if (!cy[g][65]) begin
            cx[g+1] <= cx[g] + (cy[g] >>> g);
            cy[g+1] <= cy[g] - (cx[g] >>> g);
            cz[g+1] <= cz[g] + atan_q30(5'(g));
          end else begin
            cx[g+1] <= cx[g] - (cy[g] >>> g);
            cy[g+1] <= cy[g] + (cx[g] >>> g);
            cz[g+1] <= cz[g] - atan_q30(5'(g));
          end
          cc[g+1] <= cc[g];
          cp[g+1] <= cp[g];
        end
      end
    end
  endgenerate

  logic signed [33:0] rz, rc;
  logic signed [AngleW-1:0] ang;
  logic ok;

  always_comb begin
    rz = (cz[CordicSteps] + (34'sd1 <<< (RoundS - 1))) >>> RoundS;
    rc = (rz > Hp) ? Hp : ((rz < -Hp) ? -Hp : rz);
    case (cc[CordicSteps])
      2'd1: begin
        ang = AngleW'(cp[CordicSteps] ? Hp : -Hp);
        ok = 1'b1;
      end
      2'd2: begin
        ang = AngleW'(rc);
        ok = 1'b1;
      end
      default: begin
        ang = '0;
        ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= vld[Depth-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {3'd0, ok, ang};
    end
  end

  `CPA_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  `CPA_ASSERT_ALWAYS(a_ready, clk, rst, s_tready == (!m_tvalid || m_tready), "ready does not follow the output stage")
  `CPA_ASSERT_ALWAYS(a_zero, clk, rst, !m_tvalid || m_tdata[AngleW] || m_tdata[AngleW-1:0] == '0, "invalid result carries an angle")

endmodule

[rtl/core/cpa_norm.sv]
module cpa_norm
  import cpa_pkg::*;
(
  input  logic signed [CoordW:0]  a0,
  input  logic signed [CoordW:0]  a1,
  input  logic signed [CoordW:0]  a2,
  output logic signed [NormW-1:0] v0,
  output logic signed [NormW-1:0] v1,
  output logic signed [NormW-1:0] v2,
  output logic                    nonzero
);

  logic [CoordW:0] m0, m1, m2, m;
  logic [5:0] lead;
  logic signed [CoordW+14:0] e0, e1, e2;

  always_comb begin
    m0 = a0[CoordW] ? (CoordW+1)'(-a0) : a0;
    m1 = a1[CoordW] ? (CoordW+1)'(-a1) : a1;
    m2 = a2[CoordW] ? (CoordW+1)'(-a2) : a2;
    m = m0 | m1 | m2;
    lead = '0;
    for (int k = 0; k <= CoordW; k++) begin
      if (m0[k] || m1[k] || m2[k]) begin
        lead = 6'(k);
      end
    end
    nonzero = (m != '0);
    e0 = $signed({a0, 14'd0}) >>> (6'd14 + lead - 6'd13);
    e1 = $signed({a1, 14'd0}) >>> (6'd14 + lead - 6'd13);
    e2 = $signed({a2, 14'd0}) >>> (6'd14 + lead - 6'd13);
    v0 = NormW'(e0);
    v1 = NormW'(e1);
    v2 = NormW'(e2);
  end

endmodule

[tb/ccd_pivot_angle_test.sv]
`timescale 1ns / 100ps

class pivot_angle_scoreboard;
  logic [20:0] pending_results[$];
  int errors;
  int checked;
  int flagged;

  function new();
    errors = 0;
    checked = 0;
    flagged = 0;
  endfunction

  static function longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  static function longint magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Scales a vector by a power of two so that its largest component lies in [2^13, 2^14).
  static function bit scale_vector(ref longint v[3]);
    longint m;
    int sr;
    m = magnitude(v[0]);
    sr = 0;
    if (magnitude(v[1]) > m) m = magnitude(v[1]);
    if (magnitude(v[2]) > m) m = magnitude(v[2]);
    if (m == 0) return 0;
    while ((m >> sr) >= (64'sd1 << 14)) sr++;
    for (int k = 0; k < 3; k++) v[k] = floor_shift(v[k], sr);
    m = m >> sr;
    while (m < (64'sd1 << 13)) begin
      m = m << 1;
      for (int k = 0; k < 3; k++) v[k] = v[k] * 2;
    end
    return 1;
  endfunction

  static function longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  static function longint arctan_step(int i);
    longint table_q30[10];
    table_q30 = '{843314857, 497837829, 263043837, 133525159, 67021687,
                  33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return table_q30[i];
    return 64'sd1 <<< (30 - i);
  endfunction

  static function longint round_angle(longint z);
    return floor_shift(z + (64'sd1 <<< 13), 14);
  endfunction

  static function logic [20:0] pivot_angle(logic [383:0] pts);
    longint b[3], d[3], h[3], p[3], q[3];
    longint n, t, x, y, z, r, hp, m, xs, ys;
    longint unsigned len;
    int sr;
    for (int k = 0; k < 3; k++) begin
      longint pv;
      pv = longint'($signed(pts[32*k +: 32]));
      b[k] = longint'($signed(pts[32*(3+k) +: 32])) - pv;
      h[k] = longint'($signed(pts[32*(6+k) +: 32])) - pv;
      d[k] = longint'($signed(pts[32*(9+k) +: 32])) - pv;
    end
    if (!scale_vector(b)) return '0;
    if (!scale_vector(d)) return '0;
    if (!scale_vector(h)) return '0;
    q[0] = b[1]*h[2] - b[2]*h[1];
    q[1] = b[2]*h[0] - b[0]*h[2];
    q[2] = b[0]*h[1] - b[1]*h[0];
    p[0] = b[1]*d[2] - b[2]*d[1];
    p[1] = b[2]*d[0] - b[0]*d[2];
    p[2] = b[0]*d[1] - b[1]*d[0];
    n = p[0]*q[0] + p[1]*q[1] + p[2]*q[2];
    t = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
    hp = round_angle(longint'(cpa_pkg::HalfPiQ30));
    if (n < 0) return '0;
    if (n == 0) begin
      if (t == 0) return '0;
      r = t > 0 ? hp : -hp;
    end else begin
      m = magnitude(n);
      sr = 0;
      if (magnitude(t) > m) m = magnitude(t);
      while ((m >> sr) >= (64'sd1 << 29)) sr++;
      n = floor_shift(n, sr);
      t = floor_shift(t, sr);
      m = m >> sr;
      while (m < (64'sd1 << 28)) begin
        m = m << 1;
        n = n * 2;
        t = t * 2;
      end
      len = int_sqrt(longint'(b[0]*b[0] + b[1]*b[1] + b[2]*b[2]) << 32);
      x = n * 65536;
      y = longint'(len) * t;
      z = 0;
      for (int i = 0; i < 31; i++) begin
        xs = floor_shift(x, i);
        ys = floor_shift(y, i);
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + arctan_step(i);
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - arctan_step(i);
        end
      end
      r = round_angle(z);
      if (r > hp) r = hp;
      if (r < -hp) r = -hp;
    end
    return {1'b1, r[19:0]};
  endfunction

  function void note_geometry(logic [383:0] pts);
    pending_results = {pending_results, pivot_angle(pts)};
  endfunction

  function void check_angle(logic [23:0] data);
    logic [20:0] want;
    if (pending_results.size() == 0) begin
      $error("unexpected result item %h", data);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    checked++;
    if (want[20]) flagged++;
    if (data[19:0] !== want[19:0]) begin
      $error("rotation_angle expected %h actual %h", want[19:0], data[19:0]);
      errors++;
    end
    if (data[20] !== want[20]) begin
      $error("angle_valid expected %b actual %b", want[20], data[20]);
      errors++;
    end
  endfunction
endclass

module ccd_pivot_angle_test;
  import cpa_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [383:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [23:0] m_tdata;

  pivot_angle_scoreboard board = new();
  longint cycle_count = 0;
  int hold_off = 0;
  bit steady = 0;

  ccd_pivot_angle dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_angle(m_tdata);
    if (rst) begin
      m_tready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 17);
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(2000)) - 1000);
      default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic logic [383:0] random_geometry();
    logic [383:0] g;
    for (int k = 0; k < 12; k++) g[32*k +: 32] = pick_coord();
    case ($urandom_range(19))
      0: g[95:0] = g[191:96];
      1: g[95:0] = g[287:192];
      2: g[95:0] = g[383:288];
      3: g[383:288] = g[287:192];
      default: ;
    endcase
    return g;
  endfunction

  task automatic send_geometry(logic [383:0] g);
    while (!steady && $urandom_range(99) < 17) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= g;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_geometry(g);
  endtask

  task automatic wait_drained();
    s_tvalid <= 0;
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [383:0] points(int px, int py, int pz, int nx, int ny, int nz,
                                          int ex, int ey, int ez, int tx, int ty, int tz);
    return {tz, ty, tx, ez, ey, ex, nz, ny, nx, pz, py, px};
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_geometry(points(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, 65536, 0));
    send_geometry(points(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, 0, 65536));
    send_geometry(points(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, 0, -65536));
    send_geometry(points(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, -65536, 0));
    send_geometry(points(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 65536, 0, 0));
    send_geometry(points(5, 5, 5, 5, 5, 5, 9, 1, 3, 4, 7, 2));
    send_geometry(points(5, 5, 5, 6, 5, 5, 5, 5, 5, 4, 7, 2));
    send_geometry(points(5, 5, 5, 6, 5, 5, 9, 1, 3, 5, 5, 5));
    send_geometry(points(0, 0, 0, 1, 0, 0, 0, 3, 1, 0, 2, 3));
    send_geometry({12{32'h7fffffff}});
    send_geometry({12{32'h80000000}});
    send_geometry(points(32'h80000000, 32'h80000000, 32'h80000000,
                         32'h7fffffff, 32'h80000000, 32'h80000000,
                         32'h80000000, 32'h7fffffff, 32'h80000000,
                         32'h80000000, 32'h7fffffff, 32'h7fffffff));
    send_geometry(points(32'h7fffffff, 0, 32'h80000000, 32'h80000000, 32'h7fffffff, 0,
                         0, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0));
    send_geometry({384{1'b1}});
    send_geometry({12{32'h55555555}} ^ {6{64'h0000000100000000}});
    send_geometry({12{32'haaaaaaaa}} ^ {6{64'h0000000000000001}});
    wait_drained();
    // Long receiver stall while the sender keeps offering items.
    hold_off = 300;
    steady = 1;
    for (int i = 0; i < 150; i++) send_geometry(random_geometry());
    steady = 0;
    for (int i = 0; i < 350; i++) send_geometry(random_geometry());
    wait_drained();
    steady = 1;
    for (int i = 0; i < 150; i++) send_geometry(random_geometry());
    steady = 0;
    for (int i = 0; i < 300; i++) send_geometry(random_geometry());
    wait_drained();
    repeat (60) @(posedge clk);
    $display("Checked %0d angle results, %0d of them valid, over extremes, degenerate axes",
             board.checked, board.flagged);
    $display("and coincident points, with random stalls on both sides.");
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
